// File: rtl/rdds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdds_pkg;

  // Window and sample geometry
  localparam int WINDOW_LEN = 16;
  localparam int ADC_BITS   = 12;
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W      = ADC_BITS + FILL_W;
  localparam int DCNT_W     = $clog2(SUM_W);

  // Hold counter and configuration widths
  localparam int HOLD_W  = 16;
  localparam int DELAY_W = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  localparam logic [HOLD_W-1:0]   HOLD_MAX     = 16'hFFFF;
  localparam logic [ADC_BITS-1:0] MARGIN_RESET = 12'd400;
  localparam logic [DELAY_W-1:0]  DELAY_RESET  = 16'd100;
  localparam logic [ADC_BITS-1:0] BASE_RESET   = 12'd0;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_MARGIN       = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SWITCH_DELAY = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BASELINE     = 2'd2;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CALIB  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_HW      = 2'd1,
    MODE_SW      = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SEL_UNKNOWN = 2'd0,
    SEL_TOP     = 2'd1,
    SEL_BOT     = 2'd2
  } sel_t;

  typedef enum logic [2:0] {
    CODE_NONE       = 3'd0,
    CODE_TOP_STRONG = 3'd1,
    CODE_BOT_STRONG = 3'd2,
    CODE_TOP_WEAK   = 3'd3,
    CODE_BOT_WEAK   = 3'd4,
    CODE_TOP_MARGIN = 3'd5,
    CODE_BOT_MARGIN = 3'd6
  } code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DSTART,
    ST_DIV,
    ST_RESP
  } state_t;

  // Window control
  typedef struct packed {
    logic rd;
    logic upd;
  } win_ctl_t;

  // Decision control
  typedef struct packed {
    logic tick;
    logic calib;
    logic avg_load;
    logic base_load;
  } ctl_cmd_t;

  // Decision status
  typedef struct packed {
    mode_t               mode;
    sel_t                sel;
    logic                pin;
    logic                dac;
    logic [ADC_BITS-1:0] top_avg;
    logic [ADC_BITS-1:0] bot_avg;
  } ctl_stat_t;

endpackage

`default_nettype wire

// File: rtl/rdds_window.sv
`timescale 1ns / 1ps
`default_nettype none

module rdds_window
  import rdds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire win_ctl_t            ctl,
  input  wire logic [ADC_BITS-1:0] top_in,
  input  wire logic [ADC_BITS-1:0] bot_in,
  output logic      [SUM_W-1:0]    top_sum,
  output logic      [SUM_W-1:0]    bot_sum,
  output logic      [FILL_W-1:0]   fill_count
);

  logic [ADC_BITS-1:0] top_mem [WINDOW_LEN];
  logic [ADC_BITS-1:0] bot_mem [WINDOW_LEN];
  logic [ADC_BITS-1:0] top_old, bot_old;
  logic [ADC_BITS-1:0] top_smp, bot_smp;
  logic [IDX_W-1:0]    write_index;
  logic                full;

  assign full = (fill_count == FILL_W'(WINDOW_LEN));

  // Oldest entries read and sample captured on transfer
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      top_old <= top_mem[write_index];
      bot_old <= bot_mem[write_index];
      top_smp <= top_in;
      bot_smp <= bot_in;
    end
  end

  // Window write
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      top_mem[write_index] <= top_smp;
      bot_mem[write_index] <= bot_smp;
    end
  end

  // Running sums, fill count and write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      top_sum     <= '0;
      bot_sum     <= '0;
      fill_count  <= '0;
      write_index <= '0;
    end else if (ctl.upd) begin
      if (full) begin
        top_sum <= top_sum - SUM_W'(top_old) + SUM_W'(top_smp);
        bot_sum <= bot_sum - SUM_W'(bot_old) + SUM_W'(bot_smp);
      end else begin
        top_sum    <= top_sum + SUM_W'(top_smp);
        bot_sum    <= bot_sum + SUM_W'(bot_smp);
        fill_count <= fill_count + 1'b1;
      end
      if (write_index == IDX_W'(WINDOW_LEN - 1)) begin
        write_index <= '0;
      end else begin
        write_index <= write_index + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rdds_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first
module rdds_div
  import rdds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [FILL_W-1:0] divisor,
  output logic                   done,
  output logic      [SUM_W-1:0]  quotient
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [FILL_W-1:0] rem;
  logic [FILL_W-1:0] dvs;
  logic [FILL_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and test against the divisor
  always_comb begin
    trial = {rem, quotient[SUM_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DCNT_W'(SUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], fits};
      rem      <= fits ? FILL_W'(trial - {1'b0, dvs}) : trial[FILL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rdds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rdds_ctrl
  import rdds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctl_cmd_t            cmd,
  input  wire logic [ADC_BITS-1:0] margin,
  input  wire logic [DELAY_W-1:0]  switch_delay,
  input  wire logic [ADC_BITS-1:0] base_value,
  input  wire logic [ADC_BITS-1:0] top_new,
  input  wire logic [ADC_BITS-1:0] bot_new,
  output ctl_stat_t                stat
);

  logic [ADC_BITS-1:0] top_avg, bot_avg, top_base, bot_base;
  mode_t               wanted_mode, current_mode;
  sel_t                current_select;
  code_t               held_code, code;
  logic [HOLD_W-1:0]   hold_count, hold_inc;
  logic                pin_level, dac_on;

  logic [ADC_BITS:0]   top_thr, bot_thr;
  logic                top_strong, bot_strong, top_new_strong, bot_new_strong;
  logic [ADC_BITS-1:0] tm, bm;

  // Strength tests against widened thresholds
  always_comb begin
    top_thr        = {1'b0, top_base} + {1'b0, margin};
    bot_thr        = {1'b0, bot_base} + {1'b0, margin};
    top_strong     = ({1'b0, top_avg} >= top_thr);
    bot_strong     = ({1'b0, bot_avg} >= bot_thr);
    top_new_strong = ({1'b0, top_new} >= top_thr);
    bot_new_strong = ({1'b0, bot_new} >= bot_thr);
    tm             = top_avg - top_base;
    bm             = bot_avg - bot_base;
    hold_inc       = (hold_count != HOLD_MAX) ? hold_count + 1'b1 : hold_count;
  end

  // Decision code
  always_comb begin
    priority if (top_strong)     code = CODE_TOP_STRONG;
    else if (bot_strong)         code = CODE_BOT_STRONG;
    else if (top_avg <= top_base) code = CODE_TOP_WEAK;
    else if (bot_avg <= bot_base) code = CODE_BOT_WEAK;
    else if (tm > bm)            code = CODE_TOP_MARGIN;
    else if (tm < bm)            code = CODE_BOT_MARGIN;
    else                         code = CODE_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_avg        <= '0;
      bot_avg        <= '0;
      top_base       <= BASE_RESET;
      bot_base       <= BASE_RESET;
      wanted_mode    <= MODE_UNKNOWN;
      current_mode   <= MODE_UNKNOWN;
      current_select <= SEL_UNKNOWN;
      held_code      <= CODE_NONE;
      hold_count     <= '0;
      pin_level      <= 1'b1;
      dac_on         <= 1'b0;
    end else begin
      // Baseline register write
      if (cmd.base_load) begin
        top_base <= base_value;
        bot_base <= base_value;
      end

      // Calibration captures the averages
      if (cmd.calib) begin
        top_base <= top_avg;
        bot_base <= bot_avg;
      end

      // New averages from the dividers
      if (cmd.avg_load) begin
        top_avg     <= top_new;
        bot_avg     <= bot_new;
        wanted_mode <= (top_new_strong && bot_new_strong) ? MODE_HW : MODE_SW;
      end

      // Millisecond tick
      if (cmd.tick) begin
        unique case (wanted_mode)
          MODE_HW: begin
            if (current_mode != MODE_HW) begin
              current_mode   <= MODE_HW;
              dac_on         <= 1'b1;
              current_select <= SEL_TOP;
              pin_level      <= 1'b0;
              held_code      <= CODE_NONE;
              hold_count     <= hold_inc;
            end else begin
              hold_count <= '0;
            end
          end
          MODE_SW: begin
            if (code != held_code) begin
              current_mode <= MODE_SW;
              hold_count   <= hold_inc;
              dac_on       <= (code == CODE_TOP_STRONG) || (code == CODE_BOT_STRONG);
              unique case (code)
                CODE_TOP_STRONG, CODE_BOT_WEAK, CODE_TOP_MARGIN: current_select <= SEL_TOP;
                CODE_BOT_STRONG, CODE_TOP_WEAK, CODE_BOT_MARGIN: current_select <= SEL_BOT;
                default: ;
              endcase
              if (hold_inc >= switch_delay) begin
                pin_level <= !(top_strong || bot_strong);
                held_code <= code;
              end else begin
                held_code <= CODE_NONE;
              end
            end else begin
              hold_count <= '0;
            end
          end
          default: begin
            hold_count <= hold_inc;
          end
        endcase
      end
    end
  end

  assign stat = '{mode:    current_mode,
                  sel:     current_select,
                  pin:     pin_level,
                  dac:     dac_on,
                  top_avg: top_avg,
                  bot_avg: bot_avg};

endmodule

`default_nettype wire

// File: rtl/dual_rssi_diversity_selector.sv
`timescale 1ns / 1ps
`default_nettype none

// Dual RSSI diversity selector. Each accepted item gives exactly one result showing the
// state after the item. cmd 0 pushes a top/bottom sample pair into 16-entry moving-average
// windows; the averages are the running sums divided by the fill count in two bit-serial
// restoring dividers, one quotient bit per clock; a sample passes ST_SUM, ST_DSTART and
// ST_DIV, then ST_RESP loads the output register. cmd 1 (millisecond tick), cmd 2
// (calibrate baselines from the current averages) and cmd 3 (no effect) go straight to
// ST_RESP. One item is in flight at a time; a pending result sits in the output register
// and holds off the input while the receiver stalls it. Configuration (margin,
// switch_delay, baseline_default) is to be written through cfg_write/cfg_index/cfg_data
// only while idle; the block does not enforce this. Writing baseline_default also loads
// both baselines. Unknown indexes are ignored.
module dual_rssi_diversity_selector
  import rdds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          cmd,
  input  wire logic [ADC_BITS-1:0] top_level,
  input  wire logic [ADC_BITS-1:0] bot_level,
  // output channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [1:0]          control_mode,
  output logic      [1:0]          video_select,
  output logic                     status_pin,
  output logic                     dac_enable,
  output logic      [ADC_BITS-1:0] top_average,
  output logic      [ADC_BITS-1:0] bot_average,
  // configuration
  input  wire logic                cfg_write,
  input  wire logic [CIDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  state_t              state, state_next;
  logic                accept;
  win_ctl_t            win_ctl;
  ctl_cmd_t            ctl_cmd;
  ctl_stat_t           stat;
  logic [SUM_W-1:0]    top_sum, bot_sum, top_q, bot_q;
  logic [FILL_W-1:0]   fill_count;
  logic                div_start, top_done, bot_done;
  logic [ADC_BITS-1:0] margin;
  logic [DELAY_W-1:0]  switch_delay;

  assign accept = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      margin       <= MARGIN_RESET;
      switch_delay <= DELAY_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_MARGIN) margin <= cfg_data[ADC_BITS-1:0];
      if (cfg_index == REG_SWITCH_DELAY) switch_delay <= cfg_data[DELAY_W-1:0];
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd_t'(cmd) == CMD_SAMPLE) ? ST_SUM : ST_RESP;
        end
      end
      ST_SUM:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV: begin
        if (top_done && bot_done) state_next = ST_RESP;
      end
      ST_RESP:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall          = (state != ST_IDLE) || (out_valid && out_stall);
    win_ctl.rd        = accept && (cmd_t'(cmd) == CMD_SAMPLE);
    win_ctl.upd       = (state == ST_SUM);
    div_start         = (state == ST_DSTART);
    ctl_cmd.tick      = accept && (cmd_t'(cmd) == CMD_TICK);
    ctl_cmd.calib     = accept && (cmd_t'(cmd) == CMD_CALIB);
    ctl_cmd.avg_load  = (state == ST_DIV) && top_done && bot_done;
    ctl_cmd.base_load = cfg_write && (cfg_index == REG_BASELINE);
  end

  rdds_window u_window (
    .clk        (clk),
    .rst        (rst),
    .ctl        (win_ctl),
    .top_in     (top_level),
    .bot_in     (bot_level),
    .top_sum    (top_sum),
    .bot_sum    (bot_sum),
    .fill_count (fill_count)
  );

  rdds_div u_top_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (top_sum),
    .divisor  (fill_count),
    .done     (top_done),
    .quotient (top_q)
  );

  // Runs in lockstep with the top divider
  rdds_div u_bot_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bot_sum),
    .divisor  (fill_count),
    .done     (bot_done),
    .quotient (bot_q)
  );

  rdds_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctl_cmd),
    .margin       (margin),
    .switch_delay (switch_delay),
    .base_value   (cfg_data[ADC_BITS-1:0]),
    .top_new      (top_q[ADC_BITS-1:0]),
    .bot_new      (bot_q[ADC_BITS-1:0]),
    .stat         (stat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESP) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP) begin
      control_mode <= stat.mode;
      video_select <= stat.sel;
      status_pin   <= stat.pin;
      dac_enable   <= stat.dac;
      top_average  <= stat.top_avg;
      bot_average  <= stat.bot_avg;
    end
  end

endmodule

`default_nettype wire

// File: tb/dual_rssi_diversity_selector_test.sv
`timescale 1ns / 1ps

module dual_rssi_diversity_selector_test;
  import rdds_pkg::*;

  localparam logic [1:0]        CMD_UNUSED  = 2'd3;
  localparam logic [CIDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam int                ADC_MAX     = (1 << ADC_BITS) - 1;
  localparam int                EARLY_TICKS = 40;
  localparam int                PHASE_ITEMS = 300;
  localparam int                HOLD_AT     = 200;
  localparam int                HOLD_OFF    = 400;
  localparam int                QUIET_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [ADC_BITS-1:0] top;
    logic [ADC_BITS-1:0] bot;
  } rssi_item_t;

  // Block ports
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic [1:0]          cmd       = '0;
  logic [ADC_BITS-1:0] top_level = '0;
  logic [ADC_BITS-1:0] bot_level = '0;
  logic                out_stall = 1'b0;
  logic                cfg_write = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;
  logic                in_stall;
  logic                out_valid;
  logic [1:0]          control_mode;
  logic [1:0]          video_select;
  logic                status_pin;
  logic                dac_enable;
  logic [ADC_BITS-1:0] top_average;
  logic [ADC_BITS-1:0] bot_average;

  // Stimulus and scoreboard
  rssi_item_t pending_items[$];
  ctl_stat_t  expected_status[$];
  rssi_item_t offered_item;
  int         send_idle_pct = 30;
  int         recv_idle_pct = 47;
  int         error_count   = 0;
  int         results_seen  = 0;
  int         quiet_cycles  = 0;
  int         hold_left     = 0;
  bit         hold_used     = 1'b0;

  // Selector state as predicted
  logic [ADC_BITS-1:0] cfg_margin = MARGIN_RESET;
  logic [DELAY_W-1:0]  cfg_delay  = DELAY_RESET;
  logic [ADC_BITS-1:0] cfg_base   = BASE_RESET;
  logic [ADC_BITS-1:0] top_hist [WINDOW_LEN];
  logic [ADC_BITS-1:0] bot_hist [WINDOW_LEN];
  logic [IDX_W-1:0]    wr_ptr     = '0;
  logic [FILL_W-1:0]   fill       = '0;
  logic [SUM_W-1:0]    top_acc    = '0;
  logic [SUM_W-1:0]    bot_acc    = '0;
  logic [ADC_BITS-1:0] top_mean   = '0;
  logic [ADC_BITS-1:0] bot_mean   = '0;
  logic [ADC_BITS-1:0] top_ref    = BASE_RESET;
  logic [ADC_BITS-1:0] bot_ref    = BASE_RESET;
  mode_t               want_mode  = MODE_UNKNOWN;
  mode_t               cur_mode   = MODE_UNKNOWN;
  sel_t                cur_sel    = SEL_UNKNOWN;
  code_t               held       = CODE_NONE;
  logic [HOLD_W-1:0]   hold_ctr   = '0;
  logic                pin_q      = 1'b1;
  logic                dac_q      = 1'b0;

  dual_rssi_diversity_selector DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .top_level    (top_level),
    .bot_level    (bot_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .control_mode (control_mode),
    .video_select (video_select),
    .status_pin   (status_pin),
    .dac_enable   (dac_enable),
    .top_average  (top_average),
    .bot_average  (bot_average),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Strength tests are done wide so base + margin never wraps
  function automatic bit top_is_strong();
    return int'(top_mean) >= int'(top_ref) + int'(cfg_margin);
  endfunction

  function automatic bit bot_is_strong();
    return int'(bot_mean) >= int'(bot_ref) + int'(cfg_margin);
  endfunction

  function automatic code_t pick_code();
    if (top_is_strong()) return CODE_TOP_STRONG;
    if (bot_is_strong()) return CODE_BOT_STRONG;
    if (top_mean <= top_ref) return CODE_TOP_WEAK;
    if (bot_mean <= bot_ref) return CODE_BOT_WEAK;
    if (top_mean - top_ref > bot_mean - bot_ref) return CODE_TOP_MARGIN;
    if (top_mean - top_ref < bot_mean - bot_ref) return CODE_BOT_MARGIN;
    return CODE_NONE;
  endfunction

  // Advance the predicted selector by one item and return the status it shows
  task automatic predict_status(input rssi_item_t it, output ctl_stat_t st);
    code_t            code;
    logic [SUM_W-1:0] quo;
    case (it.cmd)
      CMD_SAMPLE: begin
        if (fill >= WINDOW_LEN) begin
          top_acc = top_acc - top_hist[wr_ptr];
          bot_acc = bot_acc - bot_hist[wr_ptr];
        end else begin
          fill = fill + 1'b1;
        end
        top_hist[wr_ptr] = it.top;
        bot_hist[wr_ptr] = it.bot;
        top_acc = top_acc + it.top;
        bot_acc = bot_acc + it.bot;
        if (wr_ptr == WINDOW_LEN - 1) wr_ptr = '0;
        else wr_ptr = wr_ptr + 1'b1;
        quo = top_acc / fill;
        top_mean = quo[ADC_BITS-1:0];
        quo = bot_acc / fill;
        bot_mean = quo[ADC_BITS-1:0];
        want_mode = (top_is_strong() && bot_is_strong()) ? MODE_HW : MODE_SW;
      end
      CMD_TICK: begin
        if (hold_ctr != HOLD_MAX) hold_ctr = hold_ctr + 1'b1;
        if (want_mode == MODE_HW) begin
          if (cur_mode != MODE_HW) begin
            // hand video control over to hardware
            cur_mode = MODE_HW;
            dac_q    = 1'b1;
            cur_sel  = SEL_TOP;
            pin_q    = 1'b0;
            held     = CODE_NONE;
          end else begin
            hold_ctr = '0;
          end
        end else if (want_mode == MODE_SW) begin
          code = pick_code();
          if (code != held) begin
            cur_mode = MODE_SW;
            held     = CODE_NONE;
            dac_q    = (code == CODE_TOP_STRONG || code == CODE_BOT_STRONG);
            if (code == CODE_TOP_STRONG || code == CODE_BOT_WEAK || code == CODE_TOP_MARGIN)
              cur_sel = SEL_TOP;
            else if (code == CODE_BOT_STRONG || code == CODE_TOP_WEAK ||
                     code == CODE_BOT_MARGIN)
              cur_sel = SEL_BOT;
            // pin follows only once the decision has persisted long enough
            if (hold_ctr >= cfg_delay) begin
              pin_q = !(top_is_strong() || bot_is_strong());
              held  = code;
            end
          end else begin
            hold_ctr = '0;
          end
        end
      end
      CMD_CALIB: begin
        top_ref = top_mean;
        bot_ref = bot_mean;
      end
      default: ;
    endcase
    st.mode    = cur_mode;
    st.sel     = cur_sel;
    st.pin     = pin_q;
    st.dac     = dac_q;
    st.top_avg = top_mean;
    st.bot_avg = bot_mean;
  endtask

  // Register write; only called with nothing in flight
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MARGIN:       cfg_margin = val[ADC_BITS-1:0];
      REG_SWITCH_DELAY: cfg_delay  = val[DELAY_W-1:0];
      REG_BASELINE: begin
        cfg_base = val[ADC_BITS-1:0];
        top_ref  = cfg_base;
        bot_ref  = cfg_base;
      end
      default: ;
    endcase
  endtask

  task automatic set_regs(input int margin_val, input int delay_val, input int base_val);
    write_reg(REG_MARGIN, margin_val[CFG_W-1:0]);
    write_reg(REG_SWITCH_DELAY, delay_val[CFG_W-1:0]);
    write_reg(REG_BASELINE, base_val[CFG_W-1:0]);
  endtask

  task automatic queue_item(input logic [1:0] c, input int t, input int b);
    rssi_item_t it;
    it.cmd = c;
    it.top = t[ADC_BITS-1:0];
    it.bot = b[ADC_BITS-1:0];
    pending_items.push_back(it);
  endtask

  // Random value within spread of c, clipped to the ADC range
  function automatic logic [ADC_BITS-1:0] near(input int c, input int spread);
    int v;
    v = c + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    else if (v > ADC_MAX) v = ADC_MAX;
    return v[ADC_BITS-1:0];
  endfunction

  // Signal level for a run: mostly near the strong threshold or the baseline
  function automatic logic [ADC_BITS-1:0] pick_center();
    int r;
    r = $urandom_range(3);
    if (r < 2) return near(int'(cfg_base) + int'(cfg_margin), 32);
    if (r == 2) return near(int'(cfg_base), 32);
    return ADC_BITS'($urandom_range(ADC_MAX));
  endfunction

  // Runs of samples around a level, mixed with ticks, the odd calibrate and the odd unused command
  task automatic queue_random(input int count);
    int                  run_left;
    int                  r;
    bit                  twin;
    logic [ADC_BITS-1:0] tc;
    logic [ADC_BITS-1:0] bc;
    rssi_item_t          it;
    run_left = 0;
    twin     = 1'b0;
    tc       = '0;
    bc       = '0;
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(60, 10);
        twin     = ($urandom_range(99) < 15);
        tc       = pick_center();
        bc       = pick_center();
      end
      run_left--;
      r      = $urandom_range(99);
      it.top = ADC_BITS'($urandom);
      it.bot = ADC_BITS'($urandom);
      if (r < 52) begin
        it.cmd = CMD_SAMPLE;
        if ($urandom_range(19) != 0) it.top = near(int'(tc), 8);
        it.bot = twin ? it.top : near(int'(bc), 8);
      end else if (r < 94) begin
        it.cmd = CMD_TICK;
      end else if (r < 97) begin
        it.cmd = CMD_CALIB;
      end else begin
        it.cmd = CMD_UNUSED;
      end
      pending_items.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_status.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [ADC_BITS-1:0] want,
                                 input logic [ADC_BITS-1:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Driver: predict on each input transfer, then offer the next item
  always @(posedge clk) begin : drive
    ctl_stat_t status;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_status(offered_item, status);
        expected_status.push_back(status);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_item = pending_items.pop_front();
          in_valid  <= 1'b1;
          cmd       <= offered_item.cmd;
          top_level <= offered_item.top;
          bot_level <= offered_item.bot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer and drive the receiver stall
  always @(posedge clk) begin : watch
    ctl_stat_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          error_count++;
          $display("%0t: result with no expected status", $time);
        end else begin
          want = expected_status.pop_front();
          if (control_mode !== want.mode)
            report_mismatch("control_mode", ADC_BITS'(want.mode), ADC_BITS'(control_mode));
          if (video_select !== want.sel)
            report_mismatch("video_select", ADC_BITS'(want.sel), ADC_BITS'(video_select));
          if (status_pin !== want.pin)
            report_mismatch("status_pin", ADC_BITS'(want.pin), ADC_BITS'(status_pin));
          if (dac_enable !== want.dac)
            report_mismatch("dac_enable", ADC_BITS'(want.dac), ADC_BITS'(dac_enable));
          if (top_average !== want.top_avg)
            report_mismatch("top_average", want.top_avg, top_average);
          if (bot_average !== want.bot_avg)
            report_mismatch("bot_average", want.bot_avg, bot_average);
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_used && results_seen == HOLD_AT) begin
        hold_used = 1'b1;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dual_rssi_diversity_selector_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Ticks before any sample: only the hold counter advances
    for (int k = 0; k < EARLY_TICKS; k++) queue_item(CMD_TICK, $urandom, $urandom);
    wait_drained();
    write_reg(REG_SWITCH_DELAY, 16'hFFFF);
    queue_item(CMD_SAMPLE, 1000, 100);
    queue_item(CMD_TICK, 0, 0);
    queue_item(CMD_TICK, ADC_MAX, ADC_MAX);
    wait_drained();

    // Directed: hardware handover, unused command, calibration, bit patterns
    write_reg(REG_SWITCH_DELAY, 16'd2);
    write_reg(REG_UNUSED, CFG_W'($urandom));
    queue_item(CMD_SAMPLE, ADC_MAX, ADC_MAX);
    queue_item(CMD_TICK, 0, 0);
    queue_item(CMD_TICK, 0, 0);
    queue_item(CMD_UNUSED, ADC_MAX, ADC_MAX);
    queue_item(CMD_UNUSED, 0, 0);
    queue_item(CMD_CALIB, 0, 0);
    queue_item(CMD_SAMPLE, 0, 0);
    queue_item(CMD_TICK, 0, 0);
    queue_item(CMD_SAMPLE, 'hAAA, 'h555);
    queue_item(CMD_SAMPLE, 'h555, 'hAAA);
    queue_item(CMD_TICK, 0, 0);
    queue_item(CMD_TICK, 0, 0);
    queue_item(CMD_TICK, 0, 0);
    queue_item(CMD_CALIB, 0, 0);
    queue_item(CMD_SAMPLE, 0, ADC_MAX);
    queue_item(CMD_TICK, 0, 0);
    queue_item(CMD_TICK, 0, 0);
    queue_item(CMD_TICK, 0, 0);
    wait_drained();

    // Random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 47;
        recv_idle_pct = 30;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: set_regs($urandom_range(600, 100), $urandom_range(10), $urandom_range(1000));
        1: set_regs(ADC_MAX, 0, 0);
        2: set_regs(0, 65535, ADC_MAX);
        3: set_regs($urandom_range(ADC_MAX), $urandom_range(200), $urandom_range(ADC_MAX));
        4: set_regs(12, 1, 2000);
        default: set_regs($urandom_range(800), $urandom_range(30), $urandom_range(3000));
      endcase
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (error_count == 0 && expected_status.size() == 0) begin
      $display("dual_rssi_diversity_selector_test: clean");
    end else begin
      $display("dual_rssi_diversity_selector_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rdds_pkg.sv
rtl/rdds_window.sv
rtl/rdds_div.sv
rtl/rdds_ctrl.sv
rtl/dual_rssi_diversity_selector.sv
tb/dual_rssi_diversity_selector_test.sv
